// ----- rtl/deq_pkg.sv -----
package deq_pkg;

    localparam int DATA_W  = 32;
    localparam int ACT_W   = 3;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;
    localparam int DEPTH_D = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    // write enable from pointer logic to the slot memory, with the action's status
    typedef struct packed {
        logic    wr_en;
        t_status status;
    } t_upd;

endpackage

// ----- rtl/deq_ram.sv -----
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEPTH_D
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]          i_wr_addr,
    input  logic signed [deq_pkg::DATA_W-1:0] i_wr_data,
    input  logic                              i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]          i_rd_addr_b,
    output logic signed [deq_pkg::DATA_W-1:0] o_rd_data_a,
    output logic signed [deq_pkg::DATA_W-1:0] o_rd_data_b
);

    logic signed [deq_pkg::DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // a read of the entry written in the same cycle takes the new word
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
                o_rd_data_a <= i_wr_data;
            end else begin
                o_rd_data_a <= r_mem[i_rd_addr_a];
            end
            if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
                o_rd_data_b <= i_wr_data;
            end else begin
                o_rd_data_b <= r_mem[i_rd_addr_b];
            end
        end
    end

endmodule

// ----- rtl/deq_ptr.sv -----
module deq_ptr #(
    parameter int DEPTH = deq_pkg::DEPTH_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [deq_pkg::ACT_W-1:0]         i_action,
    output deq_pkg::t_upd                     o_upd,
    output logic [$clog2(DEPTH)-1:0]          o_wr_addr,
    output logic [$clog2(DEPTH)-1:0]          o_rd_front,
    output logic [$clog2(DEPTH)-1:0]          o_rd_back,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en;
    deq_pkg::t_status status;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST : p - 1'b1;
    endfunction

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        wr_en     = 1'b0;
        o_wr_addr = r_tail;
        status    = deq_pkg::STAT_OK;
        case (i_action)
            deq_pkg::ACT_PUSH_FRONT: begin
                if (r_count == FULL) begin
                    status = deq_pkg::STAT_OVERFLOW;
                end else begin
                    n_head    = ring_prev(r_head);
                    o_wr_addr = n_head;
                    wr_en     = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            deq_pkg::ACT_PUSH_BACK: begin
                if (r_count == FULL) begin
                    status = deq_pkg::STAT_OVERFLOW;
                end else begin
                    o_wr_addr = r_tail;
                    n_tail    = ring_next(r_tail);
                    wr_en     = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            deq_pkg::ACT_POP_FRONT: begin
                if (r_count == '0) begin
                    status = deq_pkg::STAT_UNDERFLOW;
                end else begin
                    n_head  = ring_next(r_head);
                    n_count = r_count - 1'b1;
                end
            end
            deq_pkg::ACT_POP_BACK: begin
                if (r_count == '0) begin
                    status = deq_pkg::STAT_UNDERFLOW;
                end else begin
                    n_tail  = ring_prev(r_tail);
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_upd.wr_en  = wr_en & i_accept;
    assign o_upd.status = status;
    assign o_rd_front   = n_head;
    assign o_rd_back    = ring_prev(n_tail);
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

// ----- rtl/double_ended_queue.sv -----
// double-ended queue of signed 32-bit words kept in a ring of DEPTH slots
// input channel: i_in_valid / o_in_stall with i_action and i_value; an
// action is one of push front, push back, pop front, pop back or query
// output channel: o_out_valid / i_out_stall; one result beat per input
// beat with the front and back words, occupancy, empty/full and status
// a beat is accepted at a clock edge where valid is high and stall is low
// timing: the accept edge updates the pointers, writes the slot memory and
// reads the new front and back slots into the memory's read registers;
// a later edge, once the result register is free, loads the result
// a new input beat is not taken until the result of the beat in flight
// has been loaded into the result register
// when the receiver stalls, the result register holds; the next input is
// still taken and waits in the read stage until the result register frees
// reset (i_rst_n low, synchronous) empties the queue and clears both
// channels; slot contents are not cleared, an empty queue reads as 0
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_D
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [deq_pkg::ACT_W-1:0]         i_action,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [deq_pkg::DATA_W-1:0] o_front_value,
    output logic signed [deq_pkg::DATA_W-1:0] o_back_value,
    output logic [deq_pkg::OCC_W-1:0]         o_occupancy,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic [deq_pkg::STAT_W-1:0]        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::t_state r_state, n_state;
    deq_pkg::t_upd   upd;

    logic          accept;
    logic          out_load;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_front;
    logic [AW-1:0] rd_back;
    logic [CW-1:0] count;

    logic signed [deq_pkg::DATA_W-1:0] rd_data_a;
    logic signed [deq_pkg::DATA_W-1:0] rd_data_b;

    deq_pkg::t_status r_stat;
    logic             r_out_valid;
    logic signed [deq_pkg::DATA_W-1:0] r_front;
    logic signed [deq_pkg::DATA_W-1:0] r_back;
    logic [deq_pkg::OCC_W-1:0]         r_occ;
    logic                              r_empty;
    logic                              r_full;
    deq_pkg::t_status                  r_stat_out;

    deq_ptr #(
        .DEPTH(DEPTH)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .o_upd      (upd),
        .o_wr_addr  (wr_addr),
        .o_rd_front (rd_front),
        .o_rd_back  (rd_back),
        .o_count    (count)
    );

    deq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (upd.wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_value),
        .i_rd_en     (accept),
        .i_rd_addr_a (rd_front),
        .i_rd_addr_b (rd_back),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = deq_pkg::ST_READ;
                end
            end
            deq_pkg::ST_READ: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_state = deq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            deq_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            deq_pkg::ST_READ: begin
                out_load = !(r_out_valid && i_out_stall);
            end
            default: begin
            end
        endcase
    end

    assign accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= deq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stat <= upd.status;
        end
        if (out_load) begin
            // pointers and count already hold the state after the action
            r_front    <= (count == '0) ? '0 : rd_data_a;
            r_back     <= (count == '0) ? '0 : rd_data_b;
            r_occ      <= deq_pkg::OCC_W'(count);
            r_empty    <= (count == '0);
            r_full     <= (count == CW'(DEPTH));
            r_stat_out <= r_stat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_occupancy   = r_occ;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_status      = r_stat_out;

endmodule
